// ===== hw/rtl/t0_apdu_byte_splitter_top_assert.svh =====
// Assertion macros for the T=0 APDU byte splitter.
`ifndef T0_APDU_BYTE_SPLITTER_TOP_ASSERT_SVH
`define T0_APDU_BYTE_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define T0A_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define T0A_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/t0apdu_pkg.sv =====
// Shared constants for the T=0 APDU byte splitter.
package t0apdu_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 9;

	localparam logic [BYTE_W-1:0]  NULL_PROC_BYTE = 8'h60;
	localparam logic [COUNT_W-1:0] DATA_LEN_MAX   = 9'd256;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DONE = 1'b1;

endpackage

// ===== hw/rtl/t0_apdu_byte_splitter_top.sv =====
// T=0 APDU byte splitter: header capture, procedure bytes, data and status output.
// An accepted line byte waits in the input register; any result it makes is then registered.
// Throughput: one line byte per cycle while the result channel is not stalled, set by the byte
// state machine between the input register and the result register.
// Reset (arst_n low, asynchronous): phase returns to expecting CLA, counts and
// header bytes clear to zero, both pipeline valids drop.
`include "t0_apdu_byte_splitter_top_assert.svh"

module t0_apdu_byte_splitter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// line byte channel
	input  logic                             line_valid,
	output logic                             line_ready,
	input  logic [t0apdu_pkg::BYTE_W-1:0]    line_byte,
	// result channel
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic                             kind,
	output logic [t0apdu_pkg::BYTE_W-1:0]    data_byte,
	output logic [t0apdu_pkg::BYTE_W-1:0]    data_index,
	output logic [t0apdu_pkg::BYTE_W-1:0]    class_byte,
	output logic [t0apdu_pkg::BYTE_W-1:0]    instr_byte,
	output logic [t0apdu_pkg::BYTE_W-1:0]    param_one,
	output logic [t0apdu_pkg::BYTE_W-1:0]    param_two,
	output logic [t0apdu_pkg::BYTE_W-1:0]    status_one,
	output logic [t0apdu_pkg::BYTE_W-1:0]    status_two,
	output logic [t0apdu_pkg::COUNT_W-1:0]   data_count
);
	import t0apdu_pkg::*;

	// Byte state machine phases
	typedef enum logic [3:0] {
		PH_CLASS    = 4'd0,
		PH_INSTR    = 4'd1,
		PH_P1       = 4'd2,
		PH_P2       = 4'd3,
		PH_LEN      = 4'd4,
		PH_PROC     = 4'd5,
		PH_DATA_ALL = 4'd6,
		PH_DATA_ONE = 4'd7,
		PH_SW2      = 4'd8
	} phase_t;

	// Input register stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Block state
	phase_t             phase_q;
	logic [BYTE_W-1:0]  cla_q, ins_q, p1_q, p2_q, sw1_q;
	logic [COUNT_W-1:0] left_q, done_q;

	// Result register
	logic               res_valid_q;
	logic               kind_q;
	logic [BYTE_W-1:0]  data_q, index_q, cla_res_q, ins_res_q, p1_res_q, p2_res_q;
	logic [BYTE_W-1:0]  sw1_res_q, sw2_res_q;
	logic [COUNT_W-1:0] count_q;

	// Next-state and result values
	phase_t             phase_n;
	logic [BYTE_W-1:0]  cla_n, ins_n, p1_n, p2_n, sw1_n;
	logic [COUNT_W-1:0] left_n, done_n;
	logic               emit;
	logic               r_kind;
	logic [BYTE_W-1:0]  r_data, r_index, r_sw1, r_sw2;
	logic [COUNT_W-1:0] r_count;

	logic               advance;
	logic [BYTE_W-1:0]  ins_inc;
	logic               ack_all, ack_one;
	logic [COUNT_W-1:0] left_dec, done_inc;

	// The held byte moves through the state machine once the result slot is free
	// or being emptied in this cycle; the input register takes a fresh byte
	// whenever it is empty or being drained, so one byte can wait behind a
	// stalled result.
	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign line_ready = !valid_s1 || advance;

	// Procedure byte decode; all complements are on 8 bits.
	assign ins_inc = ins_q + 8'd1;
	assign ack_all = (byte_s1 == ins_q) || (byte_s1 == ins_inc) || (byte_s1 == ~ins_inc);
	assign ack_one = (byte_s1 == ~ins_q);

	// Counter steps for one data byte: remaining saturates at zero, transferred
	// saturates at the maximum response length.
	assign left_dec = (left_q != '0) ? left_q - 9'd1 : left_q;
	assign done_inc = (done_q < DATA_LEN_MAX) ? done_q + 9'd1 : done_q;

	always_comb begin
		phase_n = phase_q;
		cla_n   = cla_q;
		ins_n   = ins_q;
		p1_n    = p1_q;
		p2_n    = p2_q;
		sw1_n   = sw1_q;
		left_n  = left_q;
		done_n  = done_q;
		emit    = 1'b0;
		r_kind  = KIND_DATA;
		r_data  = '0;
		r_index = '0;
		r_sw1   = '0;
		r_sw2   = '0;
		r_count = '0;
		case (phase_q)
			PH_INSTR: begin
				ins_n   = byte_s1;
				phase_n = PH_P1;
			end
			PH_P1: begin
				p1_n    = byte_s1;
				phase_n = PH_P2;
			end
			PH_P2: begin
				p2_n    = byte_s1;
				phase_n = PH_LEN;
			end
			PH_LEN: begin
				// A length of zero stands for the maximum response length
				left_n  = (byte_s1 == '0) ? DATA_LEN_MAX : {1'b0, byte_s1};
				done_n  = '0;
				phase_n = PH_PROC;
			end
			PH_PROC: begin
				if (byte_s1 == NULL_PROC_BYTE) begin
					phase_n = PH_PROC;
				end else if (ack_all) begin
					// drop an acknowledge that arrives with nothing left to move
					if (left_q != '0) phase_n = PH_DATA_ALL;
				end else if (ack_one) begin
					if (left_q != '0) phase_n = PH_DATA_ONE;
				end else begin
					sw1_n   = byte_s1;
					phase_n = PH_SW2;
				end
			end
			PH_DATA_ALL, PH_DATA_ONE: begin
				emit    = 1'b1;
				r_data  = byte_s1;
				r_index = done_q[BYTE_W-1:0];
				r_count = done_inc;
				left_n  = left_dec;
				done_n  = done_inc;
				if (phase_q == PH_DATA_ONE || left_dec == '0) phase_n = PH_PROC;
			end
			PH_SW2: begin
				emit    = 1'b1;
				r_kind  = KIND_DONE;
				r_sw1   = sw1_q;
				r_sw2   = byte_s1;
				r_count = done_q;
				left_n  = '0;
				done_n  = '0;
				phase_n = PH_CLASS;
			end
			default: begin
				// expecting CLA, and any unused phase code behaves the same
				cla_n   = byte_s1;
				phase_n = PH_INSTR;
			end
		endcase
	end

	// Input register: hold the byte until the state machine takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_valid && line_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_valid && line_ready) byte_s1 <= line_byte;
	end

	// Block state advances once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLASS;
			cla_q   <= '0;
			ins_q   <= '0;
			p1_q    <= '0;
			p2_q    <= '0;
			sw1_q   <= '0;
			left_q  <= '0;
			done_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			cla_q   <= cla_n;
			ins_q   <= ins_n;
			p1_q    <= p1_n;
			p2_q    <= p2_n;
			sw1_q   <= sw1_n;
			left_q  <= left_n;
			done_q  <= done_n;
		end
	end

	// Result register: a processed byte either loads a new result or leaves the
	// slot empty; otherwise clear it once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q    <= r_kind;
			data_q    <= r_data;
			index_q   <= r_index;
			cla_res_q <= cla_q;
			ins_res_q <= ins_q;
			p1_res_q  <= p1_q;
			p2_res_q  <= p2_q;
			sw1_res_q <= r_sw1;
			sw2_res_q <= r_sw2;
			count_q   <= r_count;
		end
	end

	assign res_valid  = res_valid_q;
	assign kind       = kind_q;
	assign data_byte  = data_q;
	assign data_index = index_q;
	assign class_byte = cla_res_q;
	assign instr_byte = ins_res_q;
	assign param_one  = p1_res_q;
	assign param_two  = p2_res_q;
	assign status_one = sw1_res_q;
	assign status_two = sw2_res_q;
	assign data_count = count_q;

	// A stalled result with a byte already held must block the line side
	`T0A_ASSERT_NOW(a_stall_blocks_line, res_valid && !res_ready && valid_s1, !line_ready, "line accepted a byte with no room")
	// A data result always counts its own byte
	`T0A_ASSERT_NOW(a_data_count_nonzero, res_valid && kind == KIND_DATA, data_count != '0, "data result with zero count")
	// Transferred count never passes the maximum response length
	`T0A_ASSERT_NOW(a_count_bound, 1'b1, done_q <= DATA_LEN_MAX, "transfer count overflow")
	// Completion returns the state machine to expecting CLA with counts cleared
	`T0A_ASSERT_NEXT(a_done_clears, advance && phase_q == PH_SW2, phase_q == PH_CLASS && done_q == '0 && left_q == '0, "completion did not clear state")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the T=0 APDU byte splitter: stimulus, prediction and checking.
`timescale 1ns / 1ps

module testbench;
	import t0apdu_pkg::*;

	// Parser phases, mirrored from the block's byte state machine
	typedef enum logic [3:0] {
		PH_CLASS    = 4'd0,
		PH_INSTR    = 4'd1,
		PH_P1       = 4'd2,
		PH_P2       = 4'd3,
		PH_LEN      = 4'd4,
		PH_PROC     = 4'd5,
		PH_DATA_ALL = 4'd6,
		PH_DATA_ONE = 4'd7,
		PH_SW2      = 4'd8
	} line_phase_t;

	// One result item as it appears on the result channel
	typedef struct packed {
		logic               kind;
		logic [BYTE_W-1:0]  data_byte;
		logic [BYTE_W-1:0]  data_index;
		logic [BYTE_W-1:0]  class_byte;
		logic [BYTE_W-1:0]  instr_byte;
		logic [BYTE_W-1:0]  param_one;
		logic [BYTE_W-1:0]  param_two;
		logic [BYTE_W-1:0]  status_one;
		logic [BYTE_W-1:0]  status_two;
		logic [COUNT_W-1:0] data_count;
	} split_item_t;

	// A queue entry below zero tells the driver to hold until every result is in
	localparam int DRAIN_MARK  = -1;
	localparam int LINE_TARGET = 1250;

	logic               clk;
	logic               arst_n;
	logic               line_valid = 1'b0;
	logic               line_ready;
	logic [BYTE_W-1:0]  line_byte  = '0;
	logic               res_valid;
	logic               res_ready  = 1'b0;
	logic               kind;
	logic [BYTE_W-1:0]  data_byte;
	logic [BYTE_W-1:0]  data_index;
	logic [BYTE_W-1:0]  class_byte;
	logic [BYTE_W-1:0]  instr_byte;
	logic [BYTE_W-1:0]  param_one;
	logic [BYTE_W-1:0]  param_two;
	logic [BYTE_W-1:0]  status_one;
	logic [BYTE_W-1:0]  status_two;
	logic [COUNT_W-1:0] data_count;

	t0_apdu_byte_splitter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (line_valid),
		.line_ready (line_ready),
		.line_byte  (line_byte),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.data_index (data_index),
		.class_byte (class_byte),
		.instr_byte (instr_byte),
		.param_one  (param_one),
		.param_two  (param_two),
		.status_one (status_one),
		.status_two (status_two),
		.data_count (data_count)
	);

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the parser, at its reset values
	// ------------------------------------------------------------------
	line_phase_t        ph         = PH_CLASS;
	logic [BYTE_W-1:0]  cap_class  = '0;
	logic [BYTE_W-1:0]  cap_instr  = '0;
	logic [BYTE_W-1:0]  cap_p1     = '0;
	logic [BYTE_W-1:0]  cap_p2     = '0;
	logic [BYTE_W-1:0]  cap_sw1    = '0;
	logic [COUNT_W-1:0] bytes_left = '0;
	logic [COUNT_W-1:0] bytes_done = '0;

	// Line bytes waiting to be driven, and results predicted but not yet seen
	int          line_bytes_q[$];
	split_item_t split_due[$];

	int mismatches    = 0;
	int bytes_queued  = 0;
	int bytes_sent    = 0;
	int apdus_queued  = 0;
	int data_seen     = 0;
	int done_seen     = 0;
	int burst_left    = 0;
	int gap_left      = 0;
	int ready_tick    = 0;
	logic [7:0] stall_pattern = 8'hFF;
	split_item_t got_item;
	split_item_t want_item;

	// Clock: 20 ns period
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reset: hold low from the start, release away from the rising edge
	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Emit one data byte: count it off against the length and the transfer total
	function automatic split_item_t take_data_byte(input logic [BYTE_W-1:0] b);
		split_item_t r;
		r = '0;
		r.kind       = KIND_DATA;
		r.data_byte  = b;
		r.data_index = bytes_done[BYTE_W-1:0];
		if (bytes_left != '0)
			bytes_left = bytes_left - 9'd1;
		if (bytes_done < DATA_LEN_MAX)
			bytes_done = bytes_done + 9'd1;
		r.class_byte = cap_class;
		r.instr_byte = cap_instr;
		r.param_one  = cap_p1;
		r.param_two  = cap_p2;
		r.data_count = bytes_done;
		return r;
	endfunction

	// Advance the parser copy by one accepted line byte and queue any result it causes
	function automatic void split_line_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] ins_inc;
		split_item_t       r;
		ins_inc = cap_instr + 8'd1;
		r = '0;
		case (ph)
		PH_INSTR: begin
			cap_instr = b;
			ph = PH_P1;
		end
		PH_P1: begin
			cap_p1 = b;
			ph = PH_P2;
		end
		PH_P2: begin
			cap_p2 = b;
			ph = PH_LEN;
		end
		PH_LEN: begin
			// a length of zero stands for the full 256 bytes
			bytes_left = (b == 8'd0) ? DATA_LEN_MAX : {1'b0, b};
			bytes_done = '0;
			ph = PH_PROC;
		end
		PH_PROC: begin
			// null byte first, then the acknowledge-all codes, then the single-byte code
			if (b == NULL_PROC_BYTE) begin
				ph = PH_PROC;
			end else if (b == cap_instr || b == ins_inc || b == ~ins_inc) begin
				if (bytes_left != '0)
					ph = PH_DATA_ALL;
			end else if (b == ~cap_instr) begin
				if (bytes_left != '0)
					ph = PH_DATA_ONE;
			end else begin
				cap_sw1 = b;
				ph = PH_SW2;
			end
		end
		PH_DATA_ALL: begin
			split_due.insert(split_due.size(), take_data_byte(b));
			if (bytes_left == '0)
				ph = PH_PROC;
		end
		PH_DATA_ONE: begin
			split_due.insert(split_due.size(), take_data_byte(b));
			ph = PH_PROC;
		end
		PH_SW2: begin
			r.kind       = KIND_DONE;
			r.class_byte = cap_class;
			r.instr_byte = cap_instr;
			r.param_one  = cap_p1;
			r.param_two  = cap_p2;
			r.status_one = cap_sw1;
			r.status_two = b;
			r.data_count = bytes_done;
			split_due.insert(split_due.size(), r);
			// header bytes stay until overwritten; counts clear
			bytes_left = '0;
			bytes_done = '0;
			ph = PH_CLASS;
		end
		default: begin
			cap_class = b;
			ph = PH_INSTR;
		end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	task automatic queue_line_byte(input int b);
		line_bytes_q.insert(line_bytes_q.size(), b);
		if (b >= 0)
			bytes_queued++;
	endtask

	// Queue one well-formed exchange with random content: header, procedure bytes,
	// data and status. Early status, stray acknowledges and null bytes are mixed in.
	task automatic queue_apdu(input logic [7:0] cla, input logic [7:0] ins,
			input logic [7:0] p1, input logic [7:0] p2, input logic [7:0] p3);
		int         left;
		int         choice;
		logic [7:0] ack;
		logic [7:0] sw1;
		logic [7:0] ins_inc;
		logic [7:0] ins_inc_n;
		logic [7:0] ins_n;
		ins_inc   = ins + 8'd1;
		ins_inc_n = ~ins_inc;
		ins_n     = ~ins;
		queue_line_byte(int'(cla));
		queue_line_byte(int'(ins));
		queue_line_byte(int'(p1));
		queue_line_byte(int'(p2));
		queue_line_byte(int'(p3));
		left = (p3 == 8'd0) ? 256 : int'(p3);
		apdus_queued++;
		forever begin
			choice = $urandom_range(0, 99);
			if (choice < 8) begin
				queue_line_byte(int'(NULL_PROC_BYTE));
			end else if (left == 0 || choice < 14) begin
				// now and then an acknowledge with nothing left to move
				if (left == 0 && $urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 3))
					0: queue_line_byte(int'(ins));
					1: queue_line_byte(int'(ins_inc));
					2: queue_line_byte(int'(ins_inc_n));
					default: queue_line_byte(int'(ins_n));
					endcase
				end
				do
					sw1 = 8'($urandom_range(0, 255));
				while (sw1 == NULL_PROC_BYTE || sw1 == ins || sw1 == ins_inc ||
					sw1 == ins_inc_n || sw1 == ins_n);
				queue_line_byte(int'(sw1));
				queue_line_byte($urandom_range(0, 255));
				break;
			end else if (choice < 45) begin
				queue_line_byte(int'(ins_n));
				queue_line_byte($urandom_range(0, 255));
				left--;
			end else begin
				case ($urandom_range(0, 2))
				0: ack = ins;
				1: ack = ins_inc;
				default: ack = ins_inc_n;
				endcase
				queue_line_byte(int'(ack));
				repeat (left) queue_line_byte($urandom_range(0, 255));
				left = 0;
			end
		end
	endtask

	// Directed opening. First exchange: INS A4, three bytes, a null byte, a single byte
	// admitted by ~INS, the rest acknowledged by INS, then ~(INS+1) with nothing left.
	// Second exchange: INS 7F, where 80 is both INS+1 and ~INS and so reads as
	// acknowledge-all. Line bytes 00 and FF set every bit both ways.
	localparam logic [7:0] OPENING_SEQ [23] = '{
		8'h00, 8'hA4, 8'hFF, 8'h00, 8'h03,
		8'h60, 8'h5B, 8'h00, 8'hA4, 8'hFF, 8'h11, 8'h5A, 8'h90, 8'h00,
		8'hFF, 8'h7F, 8'h80, 8'h7F, 8'h01,
		8'h80, 8'h55, 8'h6C, 8'h7F
	};

	initial begin
		int         n;
		logic [7:0] p3;
		foreach (OPENING_SEQ[i])
			queue_line_byte(int'(OPENING_SEQ[i]));
		queue_line_byte(DRAIN_MARK);

		// Random part: mostly well-formed exchanges, a little noise, full-length
		// transfers on a couple of fixed exchanges and a drain pause now and then
		n = 0;
		while (bytes_queued < LINE_TARGET) begin
			if ($urandom_range(0, 11) == 0) begin
				repeat ($urandom_range(1, 6)) queue_line_byte($urandom_range(0, 255));
			end else begin
				if (n == 3 || n == 45)
					p3 = 8'd0;
				else if ($urandom_range(0, 29) == 0)
					p3 = 8'($urandom_range(100, 255));
				else
					p3 = 8'($urandom_range(1, 12));
				queue_apdu(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), p3);
			end
			n++;
			if (n % 20 == 10)
				queue_line_byte(DRAIN_MARK);
		end

		// Wait for the last line byte to go, then for every result to drain
		@(posedge arst_n);
		while (line_bytes_q.size() != 0 || line_valid)
			@(posedge clk);
		while (split_due.size() != 0)
			@(posedge clk);
		// then wait on to catch any result the block should not have made
		repeat (8) @(posedge clk);

		$display("Covered %0d line bytes over %0d generated exchanges plus noise runs",
			bytes_sent, apdus_queued);
		$display("Checked %0d data results and %0d completion results",
			data_seen, done_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding", split_due.size());
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		// predict on every accepted transfer, using values from before this edge
		if (arst_n && line_valid && line_ready)
			split_line_byte(line_byte);

		if (!arst_n) begin
			line_valid <= 1'b0;
		end else if (line_valid && !line_ready) begin
			// hold the byte until it is taken
		end else if (gap_left > 0) begin
			gap_left--;
			line_valid <= 1'b0;
		end else if (line_bytes_q.size() == 0) begin
			line_valid <= 1'b0;
		end else if (line_bytes_q[0] == DRAIN_MARK) begin
			// pause until every predicted result has been seen
			line_valid <= 1'b0;
			if (!line_valid && split_due.size() == 0)
				void'(line_bytes_q.pop_front());
		end else begin
			line_valid <= 1'b1;
			line_byte  <= 8'(line_bytes_q.pop_front());
			bytes_sent++;
			burst_left--;
			if (burst_left <= 0) begin
				// mostly short bursts with gaps, sometimes a long unbroken run
				if ($urandom_range(0, 5) == 0) begin
					burst_left = $urandom_range(40, 120);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left   = $urandom_range(1, 6);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result transfer, and stall on a pattern of its own
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 60)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
			input logic [COUNT_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				got_item = '{kind, data_byte, data_index, class_byte, instr_byte,
					param_one, param_two, status_one, status_two, data_count};
				if (split_due.size() == 0) begin
					report_mismatch("result transfer with no prediction waiting");
				end else begin
					want_item = split_due.pop_front();
					check_field("kind", COUNT_W'(got_item.kind),
						COUNT_W'(want_item.kind));
					check_field("data_byte", COUNT_W'(got_item.data_byte),
						COUNT_W'(want_item.data_byte));
					check_field("data_index", COUNT_W'(got_item.data_index),
						COUNT_W'(want_item.data_index));
					check_field("class_byte", COUNT_W'(got_item.class_byte),
						COUNT_W'(want_item.class_byte));
					check_field("instr_byte", COUNT_W'(got_item.instr_byte),
						COUNT_W'(want_item.instr_byte));
					check_field("param_one", COUNT_W'(got_item.param_one),
						COUNT_W'(want_item.param_one));
					check_field("param_two", COUNT_W'(got_item.param_two),
						COUNT_W'(want_item.param_two));
					check_field("status_one", COUNT_W'(got_item.status_one),
						COUNT_W'(want_item.status_one));
					check_field("status_two", COUNT_W'(got_item.status_two),
						COUNT_W'(want_item.status_two));
					check_field("data_count", got_item.data_count, want_item.data_count);
				end
				if (got_item.kind == KIND_DONE)
					done_seen++;
				else
					data_seen++;
			end

			// pick a new stall pattern by the tick counter; full readiness is the most common
			if (ready_tick % 48 == 0) begin
				case ($urandom_range(0, 4))
				0, 1: stall_pattern = 8'hFF;
				2: stall_pattern = 8'($urandom_range(0, 255));
				3: stall_pattern = 8'h11;
				default: stall_pattern = 8'h00;
				endcase
			end
			res_ready <= stall_pattern[ready_tick % 8];
			ready_tick++;
		end
	end

endmodule
